>>> rtl/core/aae_pkg.sv
package aae_pkg;

  localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;
  localparam logic [31:0] FIRST_QTR = 32'h4000_0000;
  localparam logic [15:0] RESCALE_LIMIT = 16'h8000;
  localparam logic [8:0] PENDING_MAX = 9'd480;
  localparam logic [6:0] MAX_RESULTS = 7'd64;
  localparam logic [3:0] BYTE_BITS = 4'd8;

  localparam logic REQ_ENCODE = 1'b0;
  localparam logic REQ_FINISH = 1'b1;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_WALK,
    ST_MUL,
    ST_DIV_HI,
    ST_DIV_LO,
    ST_RENORM,
    ST_EMIT_FIRST,
    ST_EMIT_PEND,
    ST_EMIT_ZERO,
    ST_RESCALE,
    ST_UPDATE
  } back_state_t;

  typedef struct packed {
    logic       finish;
    logic [7:0] symbol;
  } item_t;

endpackage

>>> rtl/core/aae_if.sv
interface aae_req_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] symbol;
  modport source(output valid, req_type, symbol, input ready);
  modport sink(input valid, req_type, symbol, output ready);
endinterface

interface aae_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       kept;
  logic       stream_end;
  logic       pending_overflow;
  modport source(output valid, out_byte, kept, stream_end, pending_overflow, input ready);
  modport sink(input valid, out_byte, kept, stream_end, pending_overflow, output ready);
endinterface

interface aae_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] data;
  modport source(output valid, data, input ready);
  modport sink(input valid, data, output ready);
endinterface

>>> rtl/core/aae_ram.sv
module aae_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256,
  parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/aae_div.sv
module aae_div #(
  parameter int NW = 49,
  parameter int DW = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic          done,
  output logic [NW-1:0] quotient
);

  localparam int CW = $clog2(NW + 1);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [DW-1:0] rem;
  logic [NW-1:0] quo;
  logic [DW:0]   rem_sh;
  logic          ge;
  logic [DW-1:0] rem_next;

  assign rem_sh = {rem, quo[NW-1]};
  assign ge = rem_sh >= {1'b0, divisor};
  assign rem_next = ge ? DW'(rem_sh - {1'b0, divisor}) : rem_sh[DW-1:0];
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        quo <= dividend;
        rem <= '0;
        cnt <= CW'(NW);
      end else if (busy) begin
        rem <= rem_next;
        quo <= {quo[NW-2:0], ge};
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

>>> rtl/core/aae_fifo.sv
module aae_fifo
  import aae_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  output logic  valid,
  output item_t head,
  input  logic  pop
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  item_t         slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full = count == CW'(DEPTH);
  assign valid = count != '0;
  assign head = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> rtl/core/aae_front.sv
module aae_front
  import aae_pkg::*;
#(
  parameter int SYMBOL_COUNT = 256
) (
  aae_req_if.sink req,
  input  logic    hold,
  input  logic    full,
  output logic    push,
  output item_t   push_item
);

  logic accept;
  logic in_range;

  assign req.ready = !full && !hold;
  assign accept = req.valid && req.ready;
  assign in_range = {1'b0, req.symbol} < 9'(SYMBOL_COUNT);

  // Encode requests for symbols outside the alphabet are taken and dropped.
  assign push = accept && ((req.req_type == REQ_FINISH) || in_range);
  assign push_item.finish = req.req_type == REQ_FINISH;
  assign push_item.symbol = req.symbol;

endmodule

>>> rtl/core/aae_back.sv
module aae_back
  import aae_pkg::*;
#(
  parameter int SYMBOL_COUNT = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  input  item_t       q_item,
  output logic        q_pop,
  input  logic [31:0] byte_limit,
  output logic        init_busy,
  aae_res_if.source   res
);

  localparam int SW = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
  localparam int IW = SW + 1;
  localparam logic [SW-1:0] LAST_IDX = SW'(SYMBOL_COUNT - 1);

  back_state_t st;
  back_state_t st_next;
  back_state_t after_pend;

  logic [31:0]   low;
  logic [31:0]   high;
  logic [8:0]    pending;
  logic [7:0]    acc;
  logic [3:0]    bn;
  logic [31:0]   pos;
  logic          ovf;
  logic [15:0]   total;
  logic          cur_fin;
  logic [SW-1:0] cur_sym;
  logic [IW-1:0] idx;
  logic          rd_v;
  logic [SW-1:0] rd_idx;
  logic [15:0]   sum;
  logic [15:0]   cnt_s;
  logic [15:0]   cum_lo;
  logic [15:0]   cum_hi;
  logic          rescaled;
  logic [15:0]   rsum;
  logic          eb;
  logic [9:0]    rep;
  logic [3:0]    zcnt;
  logic [6:0]    res_cnt;
  logic [48:0]   prod_hi;
  logic [48:0]   prod_lo;
  logic [32:0]   q_hi;
  logic          div_kick;
  logic          out_valid;
  logic [7:0]    out_byte;
  logic          out_kept;
  logic          out_end;
  logic          out_ovf;

  logic          ram_we;
  logic [SW-1:0] ram_waddr;
  logic [15:0]   ram_wdata;
  logic [SW-1:0] ram_raddr;
  logic [15:0]   ram_rdata;
  logic          rd_issue;
  logic          put_en;
  logic          put_val;

  logic          can_put;
  logic [7:0]    acc_put;
  logic          byte_done;
  logic          emit_res;
  logic [32:0]   range;
  logic [15:0]   half_val;
  logic [15:0]   cnt_base;
  logic [15:0]   cnt_upd;
  logic [15:0]   divisor;
  logic [48:0]   dividend;
  logic          div_done;
  logic [48:0]   quotient;
  logic          emit_hit;
  logic          underflow;

  aae_ram #(.WIDTH(16), .DEPTH(SYMBOL_COUNT)) u_counts (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  aae_div #(.NW(49), .DW(16)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_kick),
    .dividend (dividend),
    .divisor  (divisor),
    .done     (div_done),
    .quotient (quotient)
  );

  assign can_put = !out_valid || res.ready;
  assign acc_put = {put_val, acc[7:1]};
  assign byte_done = bn == 4'd1;
  assign emit_res = put_en && byte_done && (res_cnt < MAX_RESULTS);
  assign range = {1'b0, high} - {1'b0, low} + 33'd1;
  assign half_val = 16'((17'(ram_rdata) + 17'd1) >> 1);
  assign cnt_base = rescaled ? 16'((17'(cnt_s) + 17'd1) >> 1) : cnt_s;
  assign cnt_upd = cnt_base + 16'd1;
  assign divisor = (total == '0) ? 16'd1 : total;
  assign dividend = (st == ST_DIV_HI) ? prod_hi : prod_lo;
  assign emit_hit = !high[31] || low[31];
  assign underflow = low[30] && !high[30];
  assign after_pend = cur_fin ? ST_EMIT_ZERO : ST_RENORM;
  assign init_busy = st == ST_INIT;

  assign res.valid = out_valid;
  assign res.out_byte = out_byte;
  assign res.kept = out_kept;
  assign res.stream_end = out_end;
  assign res.pending_overflow = out_ovf;

  always_comb begin
    st_next = st;
    unique case (st)
      ST_INIT: begin
        if (idx == IW'(SYMBOL_COUNT - 1)) st_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (q_valid) st_next = q_item.finish ? ST_EMIT_FIRST : ST_WALK;
      end
      ST_WALK: begin
        if (rd_v && rd_idx == cur_sym) st_next = ST_MUL;
      end
      ST_MUL: st_next = ST_DIV_HI;
      ST_DIV_HI: begin
        if (div_done) st_next = ST_DIV_LO;
      end
      ST_DIV_LO: begin
        if (div_done) st_next = ST_RENORM;
      end
      ST_RENORM: begin
        if (emit_hit) st_next = ST_EMIT_FIRST;
        else if (underflow) st_next = ST_RENORM;
        else if (total >= RESCALE_LIMIT) st_next = ST_RESCALE;
        else st_next = ST_UPDATE;
      end
      ST_EMIT_FIRST: begin
        if (can_put) st_next = (rep == '0) ? after_pend : ST_EMIT_PEND;
      end
      ST_EMIT_PEND: begin
        if (can_put && rep == 10'd1) st_next = after_pend;
      end
      ST_EMIT_ZERO: begin
        if (can_put && zcnt == 4'd1) st_next = ST_INIT;
      end
      ST_RESCALE: begin
        if (rd_v && rd_idx == LAST_IDX) st_next = ST_UPDATE;
      end
      ST_UPDATE: st_next = ST_IDLE;
      default: st_next = ST_INIT;
    endcase
  end

  always_comb begin
    ram_we = 1'b0;
    ram_waddr = idx[SW-1:0];
    ram_wdata = 16'd1;
    ram_raddr = idx[SW-1:0];
    rd_issue = 1'b0;
    put_en = 1'b0;
    put_val = 1'b0;
    q_pop = 1'b0;
    unique case (st)
      ST_INIT: ram_we = 1'b1;
      ST_IDLE: q_pop = q_valid;
      ST_WALK: rd_issue = idx <= {1'b0, cur_sym};
      ST_RESCALE: begin
        rd_issue = idx <= {1'b0, LAST_IDX};
        ram_we = rd_v;
        ram_waddr = rd_idx;
        ram_wdata = half_val;
      end
      ST_UPDATE: begin
        ram_we = 1'b1;
        ram_waddr = cur_sym;
        ram_wdata = cnt_upd;
      end
      ST_EMIT_FIRST: begin
        put_en = can_put;
        put_val = eb;
      end
      ST_EMIT_PEND: begin
        put_en = can_put;
        put_val = !eb;
      end
      ST_EMIT_ZERO: put_en = can_put;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= ST_INIT;
      idx <= '0;
      rd_v <= 1'b0;
      div_kick <= 1'b0;
      out_valid <= 1'b0;
      res_cnt <= '0;
    end else begin
      st <= st_next;
      rd_v <= rd_issue;
      rd_idx <= idx[SW-1:0];
      div_kick <= (st == ST_MUL) || (st == ST_DIV_HI && div_done);
      if (rd_issue) idx <= idx + 1'b1;

      if (emit_res) begin
        out_valid <= 1'b1;
        out_byte <= acc_put;
        out_kept <= pos < byte_limit;
        out_end <= st == ST_EMIT_ZERO;
        out_ovf <= ovf;
        res_cnt <= res_cnt + 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end

      if (put_en) begin
        if (byte_done) begin
          acc <= '0;
          bn <= BYTE_BITS;
          if (pos != ALL_ONES) pos <= pos + 32'd1;
        end else begin
          acc <= acc_put;
          bn <= bn - 4'd1;
        end
      end

      unique case (st)
        ST_INIT: begin
          idx <= (idx == IW'(SYMBOL_COUNT - 1)) ? '0 : idx + 1'b1;
          low <= '0;
          high <= ALL_ONES;
          pending <= '0;
          acc <= '0;
          bn <= BYTE_BITS;
          pos <= '0;
          ovf <= 1'b0;
          total <= 16'(SYMBOL_COUNT);
        end
        ST_IDLE: begin
          if (q_valid) begin
            cur_fin <= q_item.finish;
            cur_sym <= q_item.symbol[SW-1:0];
            res_cnt <= '0;
            idx <= '0;
            sum <= '0;
            rescaled <= 1'b0;
            rsum <= '0;
            zcnt <= BYTE_BITS;
            if (q_item.finish) begin
              eb <= low >= FIRST_QTR;
              rep <= 10'(pending) + 10'd1;
              pending <= '0;
            end
          end
        end
        ST_WALK: begin
          if (rd_v) begin
            if (rd_idx == cur_sym) begin
              cnt_s <= ram_rdata;
              cum_lo <= sum;
              cum_hi <= sum + ram_rdata;
            end else begin
              sum <= sum + ram_rdata;
            end
          end
        end
        ST_MUL: begin
          prod_hi <= range * cum_hi;
          prod_lo <= range * cum_lo;
        end
        ST_DIV_HI: begin
          if (div_done) q_hi <= quotient[32:0];
        end
        ST_DIV_LO: begin
          if (div_done) begin
            low <= low + quotient[31:0];
            high <= low + q_hi[31:0] - 32'd1;
          end
        end
        ST_RENORM: begin
          if (emit_hit) begin
            eb <= !emit_hit || low[31];
            rep <= 10'(pending);
            pending <= '0;
            low <= {low[30:0], 1'b0};
            high <= {high[30:0], 1'b1};
          end else if (underflow) begin
            if (pending < PENDING_MAX) pending <= pending + 9'd1;
            else ovf <= 1'b1;
            low <= {1'b0, low[29:0], 1'b0};
            high <= {1'b1, high[29:0], 1'b1};
          end else begin
            idx <= '0;
          end
        end
        ST_EMIT_PEND: begin
          if (can_put) rep <= rep - 10'd1;
        end
        ST_EMIT_ZERO: begin
          if (can_put) zcnt <= zcnt - 4'd1;
        end
        ST_RESCALE: begin
          rescaled <= 1'b1;
          if (rd_v) rsum <= rsum + half_val;
        end
        ST_UPDATE: begin
          total <= (rescaled ? rsum : total) + 16'd1;
        end
        default: ;
      endcase
    end
  end

  a_pending_bound: assert property (@(posedge clk) disable iff (rst)
    st != ST_INIT |-> pending <= PENDING_MAX)
    else $error("pending count above saturation limit");

  a_result_bound: assert property (@(posedge clk) disable iff (rst)
    res_cnt <= MAX_RESULTS)
    else $error("result count per request above limit");

  a_emit_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(st == ST_EMIT_FIRST || st == ST_EMIT_PEND ||
                               st == ST_EMIT_ZERO))
    else $error("result raised outside a bit output state");

  a_bits_needed: assert property (@(posedge clk) disable iff (rst)
    (st != ST_INIT && $past(st) != ST_INIT) |-> (bn >= 4'd1 && bn <= BYTE_BITS))
    else $error("bit counter out of range");

endmodule

>>> rtl/core/adaptive_arith_encoder.sv
// Order-0 adaptive arithmetic encoder with a 32-bit interval. Each request either encodes
// one symbol or finishes the stream; results are packed code bytes, first bit in the least
// significant position, each tagged with whether its position lies below byte_limit.
// An encode request for symbol s walks over the count memory, one read per cycle for
// entries 0 to s, to form the cumulative bounds, then runs two bit-serial divisions,
// then the renormalization steps, which emit the output bits, and a final count update.
// When the total count reaches 32768 a rescale pass over the count memory runs before
// the update. A finish request emits its termination bits (up to 490) and then reloads
// the count memory. After reset the same reload runs before the first request is taken.
// Output bits wait while a result is held by the sink. A two-entry queue decouples
// request acceptance from the engine.
module adaptive_arith_encoder
  import aae_pkg::*;
#(
  parameter int SYMBOL_COUNT = 256
) (
  input logic       clk,
  input logic       rst,
  aae_req_if.sink   req,
  aae_res_if.source res,
  aae_cfg_if.sink   cfg
);

  logic [31:0] byte_limit;
  logic        init_busy;
  logic        push;
  item_t       push_item;
  logic        full;
  logic        q_valid;
  item_t       q_item;
  logic        q_pop;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_limit <= ALL_ONES;
    end else if (cfg.valid) begin
      byte_limit <= cfg.data;
    end
  end

  aae_front #(.SYMBOL_COUNT(SYMBOL_COUNT)) u_front (
    .req       (req),
    .hold      (init_busy),
    .full      (full),
    .push      (push),
    .push_item (push_item)
  );

  aae_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (full),
    .valid     (q_valid),
    .head      (q_item),
    .pop       (q_pop)
  );

  aae_back #(.SYMBOL_COUNT(SYMBOL_COUNT)) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop),
    .byte_limit (byte_limit),
    .init_busy  (init_busy),
    .res        (res)
  );

endmodule
